@@ design/wafold_pkg.sv @@
// Shared types and constants for the analysis window fold block.
// Used by wafold_mac and wola_analysis_window_fold_core; depends on nothing.
package wafold_pkg;

   localparam int TAP_BITS   = 24;
   localparam int INDEX_BITS = 13;
   localparam int BIN_BITS   = 10;
   localparam int FOLD_BITS  = 27;
   localparam int FRAC_BITS  = 23;
   // Only the low bits of the exact sum reach the rounded output, so the
   // accumulator wraps at this width without changing the result.
   localparam int ACC_BITS   = FRAC_BITS + FOLD_BITS;

   localparam logic [1:0] OP_LOAD_TAP = 2'd0;
   localparam logic [1:0] OP_PUSH     = 2'd1;
   localparam logic [1:0] OP_FOLD     = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FOLD,
      ST_WAIT,
      ST_OUT
   } fsm_state_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

endpackage

@@ design/wola_analysis_window_fold_core.sv @@
// Analysis window fold: sample history and window tap memories, sequencer,
// and result register. Depends on wafold_pkg and wafold_mac.
//
// Usage: items arrive on the req_ channel (req_op, req_index, req_value) and
// results leave on the rsp_ channel (rsp_bin_index, rsp_fold_value). A transfer
// happens on a clock edge where valid is high and stall is low.
// A tap load or a sample push is taken when it transfers and gives no result.
// A bin read steps through the taps of that bin, one history and one tap
// memory read per cycle, K = ceil((WINDOW_LEN - index) / FOLD_LEN) terms in
// all (6 at the default sizes), through the memory read registers, the product
// register and the accumulator, and its result is then loaded into the output register.
// One item is worked on at a time; req_stall is high meanwhile.
// The result sits in an output register, so the next item is taken while a
// result waits; a bin read that finishes while rsp_stall holds the previous
// result waits for that register before it completes.
// After reset the sample history is cleared one entry per cycle, all WINDOW_LEN
// entries, with req_stall high. Tap memory is not cleared and must be loaded
// before any bin that uses it is read.
module wola_analysis_window_fold_core
   import wafold_pkg::*;
#(
   parameter int WINDOW_LEN  = 4608,
   parameter int FOLD_LEN    = 768,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic        [1:0]            req_op,
   input  logic        [INDEX_BITS-1:0] req_index,
   input  logic signed [TAP_BITS-1:0]   req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic        [BIN_BITS-1:0]   rsp_bin_index,
   output logic signed [FOLD_BITS-1:0]  rsp_fold_value
);

   localparam int AW = $clog2(WINDOW_LEN);
   localparam logic [AW:0] WIN_W  = (AW+1)'(WINDOW_LEN);
   localparam logic [AW:0] FOLD_W = (AW+1)'(FOLD_LEN);

   fsm_state_type state_ff, state_in;

   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] age_ff, age_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic          first_ff, first_in;
   logic [BIN_BITS-1:0] bin_ff, bin_in;

   logic signed [SAMPLE_BITS-1:0] hist_mem [WINDOW_LEN];
   logic signed [TAP_BITS-1:0]    tap_mem  [WINDOW_LEN];
   logic signed [SAMPLE_BITS-1:0] hist_q_ff;
   logic signed [TAP_BITS-1:0]    tap_q_ff;

   mac_ctl_type issue_ctl;
   mac_ctl_type rd_ctl_ff;
   logic        mac_done;
   logic [FOLD_BITS-1:0] mac_fold;

   logic rsp_valid_ff, rsp_valid_in;
   logic [BIN_BITS-1:0]  rsp_bin_ff;
   logic [FOLD_BITS-1:0] rsp_fold_ff;

   logic req_xfer;
   logic rsp_load;
   logic tap_ok, bin_ok;
   logic is_load_tap, is_push, is_fold;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic [AW:0] age_sum, pos_sum, start_sum;
   logic        issue_last;
   logic [AW-1:0] start_pos;

   assign req_xfer    = req_valid && !req_stall;
   assign tap_ok      = 32'(req_index) < 32'(WINDOW_LEN);
   assign bin_ok      = 32'(req_index) < 32'(FOLD_LEN);
   assign is_load_tap = req_xfer && (req_op == OP_LOAD_TAP) && tap_ok;
   assign is_push     = req_xfer && (req_op == OP_PUSH);
   assign is_fold     = req_xfer && (req_op == OP_FOLD) && bin_ok;
   assign sample      = SAMPLE_BITS'(req_value);

   // Position of the first term: oldest sample plus the bin offset, wrapped.
   assign start_sum = {1'b0, wp_ff} + (AW+1)'(req_index);
   assign start_pos = (start_sum >= WIN_W) ? AW'(start_sum - WIN_W) : AW'(start_sum);

   assign age_sum    = {1'b0, age_ff} + FOLD_W;
   assign pos_sum    = {1'b0, pos_ff} + FOLD_W;
   assign issue_last = age_sum >= WIN_W;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == AW'(WINDOW_LEN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (is_fold) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (issue_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (mac_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall       = 1'b1;
      issue_ctl       = '0;
      rsp_load        = 1'b0;
      unique case (state_ff)
         ST_CLEAR: req_stall = 1'b1;
         ST_IDLE:  req_stall = 1'b0;
         ST_FOLD: begin
            issue_ctl.valid = 1'b1;
            issue_ctl.first = first_ff;
            issue_ctl.last  = issue_last;
         end
         ST_WAIT: req_stall = 1'b1;
         ST_OUT:  rsp_load  = !rsp_valid_ff || !rsp_stall;
         default: req_stall = 1'b1;
      endcase
   end

   // Pointers and fold sequencing.
   always_comb begin
      clr_addr_in = clr_addr_ff + AW'(1);
      wp_in       = wp_ff;
      age_in      = age_ff;
      pos_in      = pos_ff;
      first_in    = first_ff;
      bin_in      = bin_ff;
      if (is_push) begin
         wp_in = (wp_ff == AW'(WINDOW_LEN - 1)) ? '0 : wp_ff + AW'(1);
      end
      if (is_fold) begin
         age_in   = AW'(req_index);
         pos_in   = start_pos;
         first_in = 1'b1;
         bin_in   = req_index[BIN_BITS-1:0];
      end else if (state_ff == ST_FOLD) begin
         age_in   = AW'(age_sum);
         pos_in   = (pos_sum >= WIN_W) ? AW'(pos_sum - WIN_W) : AW'(pos_sum);
         first_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      age_ff   <= age_in;
      pos_ff   <= pos_in;
      first_ff <= first_in;
      bin_ff   <= bin_in;
      if (rsp_load) begin
         rsp_bin_ff  <= bin_ff;
         rsp_fold_ff <= mac_fold;
      end
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         wp_ff        <= '0;
         rd_ctl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         wp_ff        <= wp_in;
         rd_ctl_ff    <= issue_ctl;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Sample history: cleared after reset, written by pushes, read while folding.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         hist_mem[clr_addr_ff] <= '0;
      end else if (is_push) begin
         hist_mem[wp_ff] <= sample;
      end
      hist_q_ff <= hist_mem[pos_ff];
   end

   // Window taps: written by tap loads, read while folding.
   always_ff @(posedge clock) begin
      if (is_load_tap) begin
         tap_mem[AW'(req_index)] <= req_value;
      end
      tap_q_ff <= tap_mem[age_ff];
   end

   wafold_mac #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctl        (rd_ctl_ff),
      .tap        (tap_q_ff),
      .sample     (hist_q_ff),
      .done       (mac_done),
      .fold_value (mac_fold)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bin_index  = rsp_bin_ff;
   assign rsp_fold_value = rsp_fold_ff;

endmodule

@@ design/wafold_mac.sv @@
// Multiply-accumulate pipeline for one folded bin: registered product, then
// a wrapping accumulator preset with the rounding offset. Depends on wafold_pkg.
module wafold_mac
   import wafold_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mac_ctl_type                  ctl,
   input  logic signed [TAP_BITS-1:0]   tap,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic                         done,
   output logic        [FOLD_BITS-1:0]  fold_value
);

   localparam int PROD_BITS = TAP_BITS + SAMPLE_BITS;
   localparam logic [ACC_BITS-1:0] ROUND = ACC_BITS'(1) << (FRAC_BITS - 1);

   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   mac_ctl_type                 ctl_ff;
   logic        [ACC_BITS-1:0]  acc_ff, acc_in;
   logic                        done_ff;

   assign prod_in = tap * sample;

   always_comb begin
      acc_in = acc_ff;
      if (ctl_ff.valid) begin
         if (ctl_ff.first) begin
            acc_in = ACC_BITS'(prod_ff) + ROUND;
         end else begin
            acc_in = acc_ff + ACC_BITS'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (reset) begin
         ctl_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         ctl_ff  <= ctl;
         done_ff <= ctl_ff.valid && ctl_ff.last;
      end
   end

   assign done       = done_ff;
   assign fold_value = acc_ff[ACC_BITS-1:FRAC_BITS];

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for wola_analysis_window_fold_core: directed rows, then the taps of a
// spread of bins, and a random mix, all scored against a local predictor.
// Depends on wafold_pkg and the core RTL only.
module tb;
   import wafold_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_LEN  = 4608;
   localparam int FOLD_LEN    = 768;
   localparam int SAMPLE_BITS = 24;
   localparam int MIX_ITEMS   = 780;
   localparam int FOLD_BINS   = 16;
   localparam int BIN_STRIDE  = 32;
   localparam int TERMS       = WINDOW_LEN / FOLD_LEN;
   localparam int IDLE_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PRESSURE_AT = 20;
   localparam int PRESSURE_CYCLES = 300;
   localparam int SIDE_REQ = 0;
   localparam int SIDE_RSP = 1;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;
   localparam logic [TAP_BITS-1:0] Q_MIN = 24'h800000;
   localparam logic [TAP_BITS-1:0] Q_MAX = 24'h7FFFFF;

   typedef struct packed {
      logic [BIN_BITS-1:0]  bin;
      logic [FOLD_BITS-1:0] fold;
   } fold_result_type;

   typedef struct packed {
      bit                   typed;
      logic [1:0]           op;
      logic [INDEX_BITS-1:0] index;
      logic [TAP_BITS-1:0]  value;
      logic [BIN_BITS-1:0]  bin;
      logic [FOLD_BITS-1:0] fold;
   } directed_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic        [1:0]            req_op = OP_LOAD_TAP;
   logic        [INDEX_BITS-1:0] req_index = '0;
   logic signed [TAP_BITS-1:0]   req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic        [BIN_BITS-1:0]   rsp_bin_index;
   logic signed [FOLD_BITS-1:0]  rsp_fold_value;

   // Predictor state.
   longint tap_mem [WINDOW_LEN];
   longint hist_mem [WINDOW_LEN];
   int     hist_wp = 0;

   fold_result_type folds_due [$];
   int fail_count = 0;
   int calm_left [2] = '{0, 0};

   // Bin 0 reads back zero from the cleared history; bin 767 sees only the newest
   // sample (minimum) against a minimum tap, so it folds to exactly one.
   directed_row_type directed_rows [22] = '{
      '{1'b0, OP_LOAD_TAP, 13'd0,    Q_MIN, 10'd0, 27'd0},
      '{1'b0, OP_LOAD_TAP, 13'd768,  Q_MIN, 10'd0, 27'd0},
      '{1'b0, OP_LOAD_TAP, 13'd1536, Q_MIN, 10'd0, 27'd0},
      '{1'b0, OP_LOAD_TAP, 13'd2304, Q_MIN, 10'd0, 27'd0},
      '{1'b0, OP_LOAD_TAP, 13'd3072, Q_MIN, 10'd0, 27'd0},
      '{1'b0, OP_LOAD_TAP, 13'd3840, Q_MIN, 10'd0, 27'd0},
      '{1'b0, OP_LOAD_TAP, 13'd4608, Q_MAX, 10'd0, 27'd0},
      '{1'b0, OP_LOAD_TAP, INDEX_MAX, Q_MAX, 10'd0, 27'd0},
      '{1'b1, OP_FOLD,     13'd0,    24'h0, 10'd0, 27'd0},
      '{1'b0, OP_UNUSED,   INDEX_MAX, 24'hFFFFFF, 10'd0, 27'd0},
      '{1'b0, OP_FOLD,     13'd768,  24'h0, 10'd0, 27'd0},
      '{1'b0, OP_FOLD,     INDEX_MAX, 24'h0, 10'd0, 27'd0},
      '{1'b0, OP_LOAD_TAP, 13'd767,  Q_MAX, 10'd0, 27'd0},
      '{1'b0, OP_LOAD_TAP, 13'd1535, Q_MAX, 10'd0, 27'd0},
      '{1'b0, OP_LOAD_TAP, 13'd2303, Q_MAX, 10'd0, 27'd0},
      '{1'b0, OP_LOAD_TAP, 13'd3071, Q_MAX, 10'd0, 27'd0},
      '{1'b0, OP_LOAD_TAP, 13'd3839, Q_MAX, 10'd0, 27'd0},
      '{1'b0, OP_LOAD_TAP, 13'd4607, Q_MIN, 10'd0, 27'd0},
      '{1'b0, OP_PUSH,     13'd0,    Q_MAX, 10'd0, 27'd0},
      '{1'b0, OP_PUSH,     13'd0,    Q_MIN, 10'd0, 27'd0},
      '{1'b1, OP_FOLD,     13'd767,  24'h0, 10'd767, 27'd8388608},
      '{1'b1, OP_FOLD,     13'd0,    24'h0, 10'd0, 27'd0}
   };

   wola_analysis_window_fold_core #(
      .WINDOW_LEN (WINDOW_LEN),
      .FOLD_LEN   (FOLD_LEN),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_index     (req_index),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_bin_index (rsp_bin_index),
      .rsp_fold_value(rsp_fold_value)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      foreach (tap_mem[i]) begin
         tap_mem[i] = 0;
         hist_mem[i] = 0;
      end
   end

   function automatic int draw_gap(input int side);
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm_left[side] = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic logic [TAP_BITS-1:0] draw_value();
      case ($urandom_range(0, 15))
         0: return Q_MIN;
         1: return Q_MAX;
         2: return '0;
         default: return TAP_BITS'($urandom);
      endcase
   endfunction

   // Bins whose taps are all loaded before the random mix; only these and bin 0 are read there.
   function automatic int fold_bin(input int j);
      return FOLD_LEN - 1 - j * BIN_STRIDE;
   endfunction

   // Applies one accepted request to the predictor state; returns 1 when a fold result is due.
   function automatic bit predict_fold(input logic [1:0] op, input logic [INDEX_BITS-1:0] idx,
                                       input logic [TAP_BITS-1:0] val,
                                       output fold_result_type res);
      longint acc;
      longint smp;
      int     age;
      bit     due;
      due = 1'b0;
      res = '0;
      case (op)
         OP_LOAD_TAP: begin
            if (idx < WINDOW_LEN) tap_mem[idx] = longint'($signed(val));
         end
         OP_PUSH: begin
            smp = longint'($signed(val));
            if (SAMPLE_BITS < TAP_BITS) smp = (smp <<< (64 - SAMPLE_BITS)) >>> (64 - SAMPLE_BITS);
            hist_mem[hist_wp] = smp;
            hist_wp = (hist_wp == WINDOW_LEN - 1) ? 0 : hist_wp + 1;
         end
         OP_FOLD: begin
            if (idx < FOLD_LEN) begin
               acc = 0;
               // Age 0 is the oldest sample, which sits at the write pointer.
               for (age = int'(idx); age < WINDOW_LEN; age += FOLD_LEN)
                  acc += tap_mem[age] * hist_mem[(hist_wp + age) % WINDOW_LEN];
               acc = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
               res.bin = idx[BIN_BITS-1:0];
               res.fold = acc[FOLD_BITS-1:0];
               due = 1'b1;
            end
         end
         default: ;
      endcase
      return due;
   endfunction

   // Called and returns at a falling edge; holds valid high across back-to-back items.
   task automatic send_request(input logic [1:0] op, input logic [INDEX_BITS-1:0] idx,
                               input logic [TAP_BITS-1:0] val, input bit typed,
                               input fold_result_type typed_res);
      int gap;
      fold_result_type res;
      gap = draw_gap(SIDE_REQ);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_index <= idx;
      req_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (predict_fold(op, idx, val, res)) folds_due.push_back(typed ? typed_res : res);
      @(negedge clock);
   endtask

   initial begin : stimulus
      int sel;
      int pick;
      logic [INDEX_BITS-1:0] idx;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_request(directed_rows[r].op, directed_rows[r].index, directed_rows[r].value,
                      directed_rows[r].typed, {directed_rows[r].bin, directed_rows[r].fold});

      for (int j = 0; j < FOLD_BINS; j++)
         for (int k = 0; k < TERMS; k++)
            send_request(OP_LOAD_TAP, INDEX_BITS'(fold_bin(j) + k * FOLD_LEN), draw_value(),
                         1'b0, '0);

      for (int n = 0; n < MIX_ITEMS; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 25) begin
            pick = $urandom_range(0, 15);
            if (pick == 0) idx = INDEX_BITS'($urandom_range(FOLD_LEN, 8191));
            else if (pick == 1) idx = '0;
            else idx = INDEX_BITS'(fold_bin($urandom_range(0, FOLD_BINS - 1)));
            send_request(OP_FOLD, idx, draw_value(), 1'b0, '0);
         end else if (sel < 80) begin
            send_request(OP_PUSH, INDEX_BITS'($urandom), draw_value(), 1'b0, '0);
         end else if (sel < 95) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               idx = INDEX_BITS'($urandom_range(WINDOW_LEN, 8191));
            end else if (pick < 5) begin
               idx = INDEX_BITS'(fold_bin($urandom_range(0, FOLD_BINS - 1)) +
                                 $urandom_range(0, TERMS - 1) * FOLD_LEN);
            end else begin
               idx = INDEX_BITS'($urandom_range(0, WINDOW_LEN - 1));
            end
            send_request(OP_LOAD_TAP, idx, draw_value(), 1'b0, '0);
         end else begin
            send_request(OP_UNUSED, INDEX_BITS'($urandom), draw_value(), 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      while (folds_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : result_side
      int hold;
      int checked;
      fold_result_type want;
      checked = 0;
      @(negedge clock);
      forever begin
         hold = draw_gap(SIDE_RSP);
         // One long hold-off lets the output register and then the input back up.
         if (checked == PRESSURE_AT) hold = PRESSURE_CYCLES;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         checked++;
         if (folds_due.size() == 0) begin
            $display("%0t unexpected result transfer: bin %0d fold %0d", $time,
                     rsp_bin_index, rsp_fold_value);
            fail_count++;
         end else begin
            want = folds_due.pop_front();
            if (rsp_bin_index !== want.bin) begin
               $display("%0t bin_index mismatch: expected %0d, actual %0d", $time,
                        want.bin, rsp_bin_index);
               fail_count++;
            end
            if (rsp_fold_value !== $signed(want.fold)) begin
               $display("%0t fold_value mismatch on bin %0d: expected %0d, actual %0d", $time,
                        want.bin, $signed(want.fold), rsp_fold_value);
               fail_count++;
            end
         end
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("status: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
design/wafold_pkg.sv
design/wafold_mac.sv
design/wola_analysis_window_fold_core.sv
tb/tb.sv
